// ===== design/xnds_pkg.sv =====
// ----------------------------------------------------------------------------
// xnds_pkg
// Shared types and constants of the xml nesting depth scanner: byte symbol
// codes and the classified byte record that travels from front to back.
// ----------------------------------------------------------------------------
package xnds_pkg;

    typedef logic [3:0] sym_t;

    localparam sym_t SYM_OTHER  = 4'd0;
    localparam sym_t SYM_LT     = 4'd1;
    localparam sym_t SYM_GT     = 4'd2;
    localparam sym_t SYM_BANG   = 4'd3;
    localparam sym_t SYM_QMARK  = 4'd4;
    localparam sym_t SYM_SLASH  = 4'd5;
    localparam sym_t SYM_DASH   = 4'd6;
    localparam sym_t SYM_RBRACK = 4'd7;
    localparam sym_t SYM_SQUOTE = 4'd8;
    localparam sym_t SYM_DQUOTE = 4'd9;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        sym_t       sym;
        logic       space;
    } byte_info_t;

    localparam int INFO_WIDTH = $bits(byte_info_t);

    localparam int CFG_WIDTH = 16;
    localparam logic [CFG_WIDTH-1:0] DEPTH_LIMIT_RESET = 16'd256;

endpackage

// ===== design/xnds_front.sv =====
// ----------------------------------------------------------------------------
// xnds_front
// Input side: classifies each transferred byte and tags it with its byte
// offset, line and column within the current document.
// ----------------------------------------------------------------------------
module xnds_front
    import xnds_pkg::*;
#(
    parameter int POSITION_WIDTH = 24
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [7:0]                in_byte,
    input  logic                      last_byte,
    output byte_info_t                info,
    output logic [POSITION_WIDTH-1:0] offset,
    output logic [POSITION_WIDTH-1:0] line,
    output logic [POSITION_WIDTH-1:0] column
);

    localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;
    localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);

    logic [POSITION_WIDTH-1:0] offset_reg, offset_next;
    logic [POSITION_WIDTH-1:0] line_reg, line_next;
    logic [POSITION_WIDTH-1:0] column_reg, column_next;
    sym_t                      sym;

    always_comb
    begin
        case (in_byte)
            8'h3C:   sym = SYM_LT;
            8'h3E:   sym = SYM_GT;
            8'h21:   sym = SYM_BANG;
            8'h3F:   sym = SYM_QMARK;
            8'h2F:   sym = SYM_SLASH;
            8'h2D:   sym = SYM_DASH;
            8'h5D:   sym = SYM_RBRACK;
            8'h27:   sym = SYM_SQUOTE;
            8'h22:   sym = SYM_DQUOTE;
            default: sym = SYM_OTHER;
        endcase
    end

    assign info.data  = in_byte;
    assign info.last  = last_byte;
    assign info.sym   = sym;
    assign info.space = (in_byte inside {8'h20, [8'h09:8'h0D]});

    assign offset = offset_reg;
    assign line   = line_reg;
    assign column = column_reg;

    always_comb
    begin
        offset_next = offset_reg;
        line_next   = line_reg;
        column_next = column_reg;
        if (push)
        begin
            if (last_byte)
            begin
                offset_next = '0;
                line_next   = POS_ONE;
                column_next = POS_ONE;
            end
            else
            begin
                if (offset_reg != POS_MAX)
                begin
                    offset_next = offset_reg + POS_ONE;
                end
                if (in_byte == 8'h0A)
                begin
                    if (line_reg != POS_MAX)
                    begin
                        line_next = line_reg + POS_ONE;
                    end
                    column_next = POS_ONE;
                end
                else if (column_reg != POS_MAX)
                begin
                    column_next = column_reg + POS_ONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            line_reg   <= POS_ONE;
            column_reg <= POS_ONE;
        end
        else
        begin
            offset_reg <= offset_next;
            line_reg   <= line_next;
            column_reg <= column_next;
        end
    end

endmodule

// ===== design/xnds_queue.sv =====
// ----------------------------------------------------------------------------
// xnds_queue
// Two-entry queue between the classifying front and the scanning back.
// ----------------------------------------------------------------------------
module xnds_queue
    import xnds_pkg::*;
#(
    parameter int WIDTH = INFO_WIDTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             full,
    output logic             valid,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/xnds_back.sv =====
// ----------------------------------------------------------------------------
// xnds_back
// Scanner state machine: skips comments, CDATA and processing instructions,
// tracks quotes and tag nesting, and holds the per-document result.
// ----------------------------------------------------------------------------
module xnds_back
    import xnds_pkg::*;
#(
    parameter int POSITION_WIDTH = 24,
    parameter int DEPTH_WIDTH    = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    input  byte_info_t                item,
    input  logic [POSITION_WIDTH-1:0] item_offset,
    input  logic [POSITION_WIDTH-1:0] item_line,
    input  logic [POSITION_WIDTH-1:0] item_column,
    output logic                      pop,
    input  logic [DEPTH_WIDTH-1:0]    depth_limit,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic [POSITION_WIDTH-1:0] error_offset,
    output logic [POSITION_WIDTH-1:0] error_line,
    output logic [POSITION_WIDTH-1:0] error_column
);

    localparam logic [2:0] MODE_TEXT    = 3'd0;
    localparam logic [2:0] MODE_PREFIX  = 3'd1;
    localparam logic [2:0] MODE_TAG     = 3'd2;
    localparam logic [2:0] MODE_COMMENT = 3'd3;
    localparam logic [2:0] MODE_CDATA   = 3'd4;
    localparam logic [2:0] MODE_PI      = 3'd5;

    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_SINGLE = 2'd1;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_DTD   = 2'd1;
    localparam logic [1:0] ERR_DEPTH = 2'd2;

    localparam logic [1:0] OPEN_COMMENT = 2'd0;
    localparam logic [1:0] OPEN_CDATA   = 2'd1;
    localparam logic [1:0] OPEN_DOCTYPE = 2'd2;

    localparam int DW1 = DEPTH_WIDTH + 1;

    function automatic logic [3:0] opener_len(input logic [1:0] k);
        logic [3:0] len;
        case (k)
            OPEN_COMMENT: len = 4'd4;
            OPEN_CDATA:   len = 4'd9;
            OPEN_DOCTYPE: len = 4'd9;
            default:      len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] opener_char(input logic [1:0] k, input logic [3:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            OPEN_COMMENT:
            begin
                case (idx)
                    4'd2:    c = 8'h2D;
                    4'd3:    c = 8'h2D;
                    default: c = 8'h00;
                endcase
            end
            OPEN_CDATA:
            begin
                case (idx)
                    4'd2:    c = 8'h5B;
                    4'd3:    c = 8'h43;
                    4'd4:    c = 8'h44;
                    4'd5:    c = 8'h41;
                    4'd6:    c = 8'h54;
                    4'd7:    c = 8'h41;
                    4'd8:    c = 8'h5B;
                    default: c = 8'h00;
                endcase
            end
            OPEN_DOCTYPE:
            begin
                case (idx)
                    4'd2:    c = 8'h44;
                    4'd3:    c = 8'h4F;
                    4'd4:    c = 8'h43;
                    4'd5:    c = 8'h54;
                    4'd6:    c = 8'h59;
                    4'd7:    c = 8'h50;
                    4'd8:    c = 8'h45;
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    logic [2:0]                mode_reg, mode_next;
    logic [3:0]                pidx_reg, pidx_next;
    logic [2:0]                cand_reg, cand_next;
    logic [DW1-1:0]            depth_reg, depth_next;
    logic [1:0]                quote_reg, quote_next;
    logic                      closing_reg, closing_next;
    logic                      slash_reg, slash_next;
    logic [1:0]                trun_reg, trun_next;
    logic [POSITION_WIDTH-1:0] tag_offset_reg, tag_offset_next;
    logic [POSITION_WIDTH-1:0] tag_line_reg, tag_line_next;
    logic [POSITION_WIDTH-1:0] tag_column_reg, tag_column_next;
    logic [1:0]                err_reg, err_next;
    logic [1:0]                err_done;

    logic                      out_valid_reg, out_valid_next;
    logic [1:0]                status_reg;
    logic [POSITION_WIDTH-1:0] error_offset_reg;
    logic [POSITION_WIDTH-1:0] error_line_reg;
    logic [POSITION_WIDTH-1:0] error_column_reg;

    logic                      run_tag;
    logic [1:0]                tag_quote;
    logic                      tag_closing;
    logic                      tag_slash;
    logic [2:0]                keep;
    logic [2:0]                hit;
    logic [3:0]                pidx_inc;
    sym_t                      fill_sym;
    logic [1:0]                need;
    logic [DW1-1:0]            depth_inc;
    logic                      pop_last;

    assign pop       = item_valid && (!out_valid_reg || !out_stall);
    assign pop_last  = pop && item.last;
    assign pidx_inc  = pidx_reg + 4'd1;
    assign depth_inc = depth_reg + DW1'(1);

    always_comb
    begin
        mode_next       = mode_reg;
        pidx_next       = pidx_reg;
        cand_next       = cand_reg;
        depth_next      = depth_reg;
        quote_next      = quote_reg;
        closing_next    = closing_reg;
        slash_next      = slash_reg;
        trun_next       = trun_reg;
        tag_offset_next = tag_offset_reg;
        tag_line_next   = tag_line_reg;
        tag_column_next = tag_column_reg;
        err_next        = err_reg;
        run_tag         = 1'b0;
        tag_quote       = quote_reg;
        tag_closing     = closing_reg;
        tag_slash       = slash_reg;
        keep            = '0;
        hit             = '0;
        fill_sym        = SYM_DASH;
        need            = 2'd2;

        if (pop && err_reg == ERR_NONE)
        begin
            case (mode_reg)
                MODE_TEXT:
                begin
                    if (item.sym == SYM_LT)
                    begin
                        tag_offset_next = item_offset;
                        tag_line_next   = item_line;
                        tag_column_next = item_column;
                        mode_next       = MODE_PREFIX;
                        pidx_next       = 4'd1;
                        cand_next       = 3'd0;
                    end
                end
                MODE_PREFIX:
                begin
                    if (pidx_reg <= 4'd1)
                    begin
                        case (item.sym)
                            SYM_BANG:
                            begin
                                pidx_next = 4'd2;
                                cand_next = 3'd7;
                            end
                            SYM_QMARK:
                            begin
                                mode_next = MODE_PI;
                                trun_next = 2'd0;
                            end
                            SYM_SLASH:
                            begin
                                mode_next    = MODE_TAG;
                                closing_next = 1'b1;
                                quote_next   = QUOTE_NONE;
                                slash_next   = 1'b0;
                            end
                            default:
                            begin
                                mode_next    = MODE_TAG;
                                closing_next = 1'b0;
                                run_tag      = 1'b1;
                                tag_quote    = QUOTE_NONE;
                                tag_closing  = 1'b0;
                                tag_slash    = 1'b0;
                            end
                        endcase
                    end
                    else
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            keep[k] = cand_reg[k] && (pidx_reg < opener_len(2'(k)))
                                      && (opener_char(2'(k), pidx_reg) == item.data);
                            hit[k]  = keep[k] && (pidx_inc == opener_len(2'(k)));
                        end
                        cand_next = keep;
                        if (keep == 3'd0)
                        begin
                            mode_next    = MODE_TAG;
                            closing_next = 1'b0;
                            run_tag      = 1'b1;
                            tag_quote    = QUOTE_NONE;
                            tag_closing  = 1'b0;
                            tag_slash    = 1'b0;
                        end
                        else
                        begin
                            pidx_next = pidx_inc;
                            if (hit[0])
                            begin
                                trun_next = 2'd0;
                                mode_next = MODE_COMMENT;
                            end
                            else if (hit[1])
                            begin
                                trun_next = 2'd0;
                                mode_next = MODE_CDATA;
                            end
                            else if (hit[2])
                            begin
                                trun_next = 2'd0;
                                err_next  = ERR_DTD;
                            end
                        end
                    end
                end
                MODE_TAG:
                begin
                    run_tag = 1'b1;
                end
                MODE_COMMENT, MODE_CDATA, MODE_PI:
                begin
                    if (mode_reg == MODE_CDATA)
                    begin
                        fill_sym = SYM_RBRACK;
                    end
                    else if (mode_reg == MODE_PI)
                    begin
                        fill_sym = SYM_QMARK;
                        need     = 2'd1;
                    end
                    if (item.sym == SYM_GT && trun_reg >= need)
                    begin
                        mode_next = MODE_TEXT;
                        trun_next = 2'd0;
                    end
                    else if (item.sym == fill_sym)
                    begin
                        if (trun_reg < need)
                        begin
                            trun_next = trun_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        trun_next = 2'd0;
                    end
                end
                default:
                begin
                    mode_next = MODE_TEXT;
                end
            endcase

            if (run_tag)
            begin
                quote_next = tag_quote;
                slash_next = tag_slash;
                if (tag_quote == QUOTE_NONE && item.sym == SYM_GT)
                begin
                    mode_next = MODE_TEXT;
                    if (tag_closing)
                    begin
                        if (depth_reg != '0)
                        begin
                            depth_next = depth_reg - DW1'(1);
                        end
                    end
                    else if (!tag_slash)
                    begin
                        depth_next = depth_inc;
                        if (depth_inc > {1'b0, depth_limit})
                        begin
                            err_next = ERR_DEPTH;
                        end
                    end
                end
                else
                begin
                    if (!item.space)
                    begin
                        slash_next = (item.sym == SYM_SLASH);
                    end
                    if (tag_quote == QUOTE_SINGLE)
                    begin
                        if (item.sym == SYM_SQUOTE)
                        begin
                            quote_next = QUOTE_NONE;
                        end
                    end
                    else if (tag_quote == QUOTE_DOUBLE)
                    begin
                        if (item.sym == SYM_DQUOTE)
                        begin
                            quote_next = QUOTE_NONE;
                        end
                    end
                    else if (item.sym == SYM_SQUOTE)
                    begin
                        quote_next = QUOTE_SINGLE;
                    end
                    else if (item.sym == SYM_DQUOTE)
                    begin
                        quote_next = QUOTE_DOUBLE;
                    end
                end
            end
        end

        err_done = err_next;

        // rearm for the next document
        if (pop_last)
        begin
            mode_next       = MODE_TEXT;
            pidx_next       = 4'd0;
            cand_next       = 3'd0;
            depth_next      = '0;
            quote_next      = QUOTE_NONE;
            closing_next    = 1'b0;
            slash_next      = 1'b0;
            trun_next       = 2'd0;
            tag_offset_next = '0;
            tag_line_next   = '0;
            tag_column_next = '0;
            err_next        = ERR_NONE;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop_last)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_TEXT;
            pidx_reg       <= 4'd0;
            cand_reg       <= 3'd0;
            depth_reg      <= '0;
            quote_reg      <= QUOTE_NONE;
            closing_reg    <= 1'b0;
            slash_reg      <= 1'b0;
            trun_reg       <= 2'd0;
            tag_offset_reg <= '0;
            tag_line_reg   <= '0;
            tag_column_reg <= '0;
            err_reg        <= ERR_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            pidx_reg       <= pidx_next;
            cand_reg       <= cand_next;
            depth_reg      <= depth_next;
            quote_reg      <= quote_next;
            closing_reg    <= closing_next;
            slash_reg      <= slash_next;
            trun_reg       <= trun_next;
            tag_offset_reg <= tag_offset_next;
            tag_line_reg   <= tag_line_next;
            tag_column_reg <= tag_column_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload, computed from the state after the last byte
    always_ff @(posedge clk)
    begin
        if (pop_last)
        begin
            status_reg <= err_done;
            if (err_done != ERR_NONE)
            begin
                error_offset_reg <= tag_offset_reg;
                error_line_reg   <= tag_line_reg;
                error_column_reg <= tag_column_reg;
            end
            else
            begin
                error_offset_reg <= '0;
                error_line_reg   <= '0;
                error_column_reg <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign error_offset = error_offset_reg;
    assign error_line   = error_line_reg;
    assign error_column = error_column_reg;

    a_prefix_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_PREFIX && err_reg == ERR_NONE) |-> (pidx_reg >= 4'd1 && pidx_reg <= 4'd8))
        else $error("prefix index out of range");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop_last |=> out_valid_reg)
        else $error("last byte did not produce a result");

    a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !pop)
        else $error("byte taken while result slot blocked");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_NONE && !pop_last) |=> ($stable(err_reg) && $stable(tag_offset_reg)))
        else $error("error state changed before end of document");

    a_terminator_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_PI) |-> (trun_reg <= 2'd1))
        else $error("terminator run too long in processing instruction");

endmodule

// ===== design/xml_nesting_depth_scanner.sv =====
// ----------------------------------------------------------------------------
// xml_nesting_depth_scanner
// Streams an XML document byte by byte and reports, on its last byte, the
// first DOCTYPE or nesting-depth violation with its offset, line and column.
// ----------------------------------------------------------------------------
// The scanner takes one byte per clock while in_stall is low and presents
// one result per document in an output register, loaded as its last byte leaves the queue.
// Each byte is classified and tagged with its position at the input, held
// in a two-entry queue, and then run through the registered scanner state
// update; that update sets the one-byte-per-clock rate. A finished result
// sits in an output register; while it is stalled the queue takes up to two
// more bytes, then in_stall rises until the result is transferred. The depth
// limit may be rewritten between documents through cfg_wr_en and
// cfg_wr_data; only its low DEPTH_WIDTH bits are kept.
// ----------------------------------------------------------------------------
module xml_nesting_depth_scanner
    import xnds_pkg::*;
#(
    parameter int POSITION_WIDTH = 24,
    parameter int DEPTH_WIDTH    = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_WIDTH-1:0]      cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                in_byte,
    input  logic                      last_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic [POSITION_WIDTH-1:0] error_offset,
    output logic [POSITION_WIDTH-1:0] error_line,
    output logic [POSITION_WIDTH-1:0] error_column
);

    localparam int Q_WIDTH = INFO_WIDTH + 3 * POSITION_WIDTH;

    logic [DEPTH_WIDTH-1:0]           depth_limit_reg, depth_limit_next;
    logic [DEPTH_WIDTH+CFG_WIDTH-1:0] cfg_ext;
    logic [DEPTH_WIDTH+CFG_WIDTH-1:0] reset_ext;

    logic                      push;
    logic                      q_full;
    logic                      q_valid;
    logic                      pop;
    logic [Q_WIDTH-1:0]        q_wdata;
    logic [Q_WIDTH-1:0]        q_rdata;
    byte_info_t                front_info;
    byte_info_t                back_info;
    logic [POSITION_WIDTH-1:0] front_offset, front_line, front_column;
    logic [POSITION_WIDTH-1:0] back_offset, back_line, back_column;

    assign cfg_ext          = {{DEPTH_WIDTH{1'b0}}, cfg_wr_data};
    assign reset_ext        = {{DEPTH_WIDTH{1'b0}}, DEPTH_LIMIT_RESET};
    assign depth_limit_next = cfg_wr_en ? cfg_ext[DEPTH_WIDTH-1:0] : depth_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_limit_reg <= reset_ext[DEPTH_WIDTH-1:0];
        end
        else
        begin
            depth_limit_reg <= depth_limit_next;
        end
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    xnds_front #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_byte   (in_byte),
        .last_byte (last_byte),
        .info      (front_info),
        .offset    (front_offset),
        .line      (front_line),
        .column    (front_column)
    );

    assign q_wdata = {front_info, front_offset, front_line, front_column};

    xnds_queue #(
        .WIDTH (Q_WIDTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .pop   (pop),
        .full  (q_full),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    assign {back_info, back_offset, back_line, back_column} = q_rdata;

    xnds_back #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .DEPTH_WIDTH    (DEPTH_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (q_valid),
        .item         (back_info),
        .item_offset  (back_offset),
        .item_line    (back_line),
        .item_column  (back_column),
        .pop          (pop),
        .depth_limit  (depth_limit_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .error_offset (error_offset),
        .error_line   (error_line),
        .error_column (error_column)
    );

endmodule
